@@ src/cpws_pkg.sv @@
// cpws_pkg: shared sizes, types and codes for the capture period window sum.
// Used by cpws_cell and capture_period_window_sum; depends on nothing.
`timescale 1ns / 1ps

package cpws_pkg;

  // Ring and timer geometry
  localparam int RING_DEPTH   = 8;
  localparam int TIMER_WIDTH  = 16;
  localparam int THRESH_WIDTH = 20;
  localparam int TICKS_WIDTH  = 21;
  localparam int SUM_WIDTH    = 19;
  localparam int CNT_WIDTH    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ACC_WIDTH    = TIMER_WIDTH + CNT_WIDTH;

  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(65536);

  typedef logic [TIMER_WIDTH-1:0] interval_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

@@ src/capture_period_window_sum.sv @@
// capture_period_window_sum: moving sum of timer capture intervals.
// Top level: sequencer, tick total and a ring of cpws_cell. Depends on cpws_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_capture_value    | request in
//  out     | out_valid, out_ready, out_interval_sum  | request out
//  cfg     | cfg_valid, cfg_ready, cfg_report_threshold | write in
//
// An interval that keeps the tick total at or below the threshold only enters
// the ring. Otherwise the ring rotates once through all RING_DEPTH cells
// to sum and check them, then a done step posts the sum if no cell is zero.
// Synchronous active-low reset clears the ring, the total and the threshold
// to its default. A held result stalls the post step only; captures are
// taken while an earlier result waits on out_ready.
`timescale 1ns / 1ps

module capture_period_window_sum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cpws_pkg::TIMER_WIDTH-1:0]    in_capture_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cpws_pkg::SUM_WIDTH-1:0]      out_interval_sum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpws_pkg::THRESH_WIDTH-1:0]   cfg_report_threshold
);

  cpws_pkg::state_t                      state_r, state_nxt;
  logic [cpws_pkg::TIMER_WIDTH-1:0]      prev_r, prev_nxt;
  logic                                  have_prev_r, have_prev_nxt;
  logic [cpws_pkg::TICKS_WIDTH-1:0]      ticks_r, ticks_nxt;
  logic [cpws_pkg::THRESH_WIDTH-1:0]     thresh_r, thresh_nxt;
  logic [cpws_pkg::CNT_WIDTH-1:0]        cnt_r, cnt_nxt;
  logic [cpws_pkg::ACC_WIDTH-1:0]        acc_r, acc_nxt;
  logic                                  all_nz_r, all_nz_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [cpws_pkg::SUM_WIDTH-1:0]        out_sum_r, out_sum_nxt;

  logic                                  in_fire;
  logic                                  insert;
  logic                                  shift_en;
  cpws_pkg::interval_t                   delta;
  cpws_pkg::interval_t                   ring_head;
  cpws_pkg::interval_t                   ring_tail;
  logic [cpws_pkg::TICKS_WIDTH:0]        ticks_sum;
  logic [cpws_pkg::TICKS_WIDTH-1:0]      ticks_sat;
  cpws_pkg::interval_t                   cell_q [cpws_pkg::RING_DEPTH];

  assign in_ready  = (state_r == cpws_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign insert    = in_fire && have_prev_r;

  // Interval modulo the timer width and saturating tick total
  assign delta     = in_capture_value - prev_r;
  assign ticks_sum = {1'b0, ticks_r} + (cpws_pkg::TICKS_WIDTH + 1)'(delta);
  assign ticks_sat = ticks_sum[cpws_pkg::TICKS_WIDTH] ? '1
                                                      : ticks_sum[cpws_pkg::TICKS_WIDTH-1:0];

  // Ring: shift in a new interval, or rotate the tail back to the head
  assign ring_tail = cell_q[cpws_pkg::RING_DEPTH-1];
  assign ring_head = (state_r == cpws_pkg::ST_SUM) ? ring_tail : delta;
  assign shift_en  = insert || (state_r == cpws_pkg::ST_SUM);

  for (genvar i = 0; i < cpws_pkg::RING_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      cpws_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .din      (ring_head),
        .dout     (cell_q[i])
      );
    end else begin : g_body
      cpws_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .din      (cell_q[i-1]),
        .dout     (cell_q[i])
      );
    end
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    ticks_nxt     = ticks_r;
    thresh_nxt    = thresh_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    all_nz_nxt    = all_nz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sum_nxt   = out_sum_r;

    if (cfg_valid && cfg_ready) begin
      thresh_nxt = cfg_report_threshold;
    end

    case (state_r)
      cpws_pkg::ST_IDLE: begin
        if (in_fire) begin
          prev_nxt      = in_capture_value;
          have_prev_nxt = 1'b1;
          if (have_prev_r) begin
            ticks_nxt = ticks_sat;
            if (ticks_sat > cpws_pkg::TICKS_WIDTH'(thresh_r)) begin
              state_nxt  = cpws_pkg::ST_SUM;
              cnt_nxt    = '0;
              acc_nxt    = '0;
              all_nz_nxt = 1'b1;
            end
          end
        end
      end
      // One cell leaves the tail each cycle and is counted
      cpws_pkg::ST_SUM: begin
        acc_nxt    = acc_r + cpws_pkg::ACC_WIDTH'(ring_tail);
        all_nz_nxt = all_nz_r && (ring_tail != '0);
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == cpws_pkg::CNT_WIDTH'(cpws_pkg::RING_DEPTH - 1)) begin
          state_nxt = cpws_pkg::ST_DONE;
        end
      end
      // Post the sum once the output register is free; drop it if a cell is zero
      cpws_pkg::ST_DONE: begin
        if (!all_nz_r) begin
          state_nxt = cpws_pkg::ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = cpws_pkg::SUM_WIDTH'(acc_r);
          ticks_nxt     = '0;
          state_nxt     = cpws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpws_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpws_pkg::ST_IDLE;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      ticks_r     <= '0;
      thresh_r    <= cpws_pkg::THRESH_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      prev_r      <= prev_nxt;
      ticks_r     <= ticks_nxt;
      thresh_r    <= thresh_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    all_nz_r  <= all_nz_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_interval_sum = out_sum_r;

  // A new result is only posted from the final step of a sum
  a_post_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == cpws_pkg::ST_DONE))
    else $error("result posted outside the done step");

  // Posting a result clears the tick total
  a_post_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (ticks_r == '0))
    else $error("tick total not cleared on a posted result");

  // The done step always follows a complete rotation
  a_done_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpws_pkg::ST_DONE && $past(state_r) != cpws_pkg::ST_DONE)
      |-> ($past(state_r == cpws_pkg::ST_SUM) && cnt_r == '0))
    else $error("done step reached without a full rotation");

  // No ticks accumulate before the first capture is held
  a_no_ticks_before_first: assert property (@(posedge clk) disable iff (!rst_n)
    !have_prev_r |-> (ticks_r == '0 && state_r == cpws_pkg::ST_IDLE))
    else $error("activity before the first capture");

endmodule

@@ src/cpws_cell.sv @@
// cpws_cell: one ring cell holding a single capture interval.
// Shifts its neighbor's value in when enabled. Depends on cpws_pkg.
`timescale 1ns / 1ps

module cpws_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  cpws_pkg::interval_t din,
  output cpws_pkg::interval_t dout
);

  cpws_pkg::interval_t value_r;
  cpws_pkg::interval_t value_nxt;

  // Take the neighbor's value on a shift, hold otherwise
  always_comb begin
    value_nxt = shift_en ? din : value_r;
  end

  // Ring clears to zero so an unfilled slot blocks reports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign dout = value_r;

endmodule
